### hw/rtl/weighted_moment_accumulator_assert.svh
// assertion macros shared by the weighted moment accumulator modules
`ifndef WEIGHTED_MOMENT_ACCUMULATOR_ASSERT_SVH
`define WEIGHTED_MOMENT_ACCUMULATOR_ASSERT_SVH

// condition in this cycle implies consequence in the same cycle
`define WMA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define WMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/wma_pkg.sv
// shared widths, types and constants of the weighted moment accumulator
`timescale 1ns / 1ps

package wma_pkg;

   // input field widths
   localparam int OFFSET_W = 11;
   localparam int WEIGHT_W = 17;
   localparam int VALUE_W  = 16;

   // accumulator widths
   localparam int SUM_W_W   = 29;
   localparam int SUM_WW_W  = 45;
   localparam int SUM_WD_W  = 44;
   localparam int SUM_MOM_W = 64;

   // result widths
   localparam int FLUX_W   = 36;
   localparam int MOMENT_W = 40;
   localparam int STATUS_W = 2;

   // object queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // serial divider
   localparam int DIV_NUM_W = 80;
   localparam int DIV_DEN_W = SUM_WW_W;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // finished sums of one object
   typedef struct packed {
      logic        [SUM_W_W-1:0]   sum_weight;
      logic        [SUM_WW_W-1:0]  sum_weight_sq;
      logic signed [SUM_WD_W-1:0]  sum_weighted_data;
      logic signed [SUM_MOM_W-1:0] sum_wd_xx;
      logic signed [SUM_MOM_W-1:0] sum_wd_yy;
      logic signed [SUM_MOM_W-1:0] sum_wd_xy;
   } sums_type;

   // divider request and response
   typedef struct packed {
      logic                 go;
      logic [DIV_NUM_W-1:0] numerator;
      logic [DIV_DEN_W-1:0] denominator;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

### hw/rtl/weighted_moment_accumulator.sv
// weighted moment accumulator: pixel front end, object queue, division back end
// pixels: one per cycle while busy is low; the sums pass through the capture, product,
//    moment-term and accumulator stages; result: the flux division only, or flux and the
//    three moment divisions with shape moments, none when the weight-square sum is zero;
//    each division is an 80-step serial divider, one quotient bit per cycle
// busy is high while two objects with their last pixel accepted wait for the back end; the result
//    strobe lasts one cycle and cannot be held off
// reset: sums cleared, queue emptied, shape_enable set, clip_negative_flux clear
`timescale 1ns / 1ps

module weighted_moment_accumulator import wma_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [OFFSET_W-1:0] req_offset_x,
   input  logic signed [OFFSET_W-1:0] req_offset_y,
   input  logic        [WEIGHT_W-1:0] req_pixel_weight,
   input  logic signed [VALUE_W-1:0]  req_pixel_value,
   input  logic                       req_last_pixel,
   output logic                       rsp_valid,
   output logic signed [FLUX_W-1:0]   rsp_flux_value,
   output logic signed [MOMENT_W-1:0] rsp_moment_xx,
   output logic signed [MOMENT_W-1:0] rsp_moment_yy,
   output logic signed [MOMENT_W-1:0] rsp_moment_xy,
   output logic        [STATUS_W-1:0] rsp_result_status,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [CSR_ADDR_W-1:0]      paddr,
   input  logic [CSR_DATA_W-1:0]      pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   localparam logic CSR_SHAPE_ENABLE = 1'b0;
   localparam logic CSR_CLIP_FLUX    = 1'b1;

   logic        csr_write;
   logic        csr_index;
   logic        shape_enable_in;
   logic        shape_enable_ff;
   logic        clip_flux_in;
   logic        clip_flux_ff;

   logic        push;
   sums_type    push_data;
   logic        queue_pop;
   sums_type    queue_head;
   logic        queue_empty;
   div_req_type div_req;
   div_rsp_type div_rsp;

   // configuration registers
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[2];

   always_comb begin
      shape_enable_in = shape_enable_ff;
      clip_flux_in    = clip_flux_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SHAPE_ENABLE: shape_enable_in = pwdata[0];
            CSR_CLIP_FLUX:    clip_flux_in    = pwdata[0];
            default:          shape_enable_in = shape_enable_ff;
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (csr_index)
         CSR_SHAPE_ENABLE: prdata = {{(CSR_DATA_W - 1){1'b0}}, shape_enable_ff};
         CSR_CLIP_FLUX:    prdata = {{(CSR_DATA_W - 1){1'b0}}, clip_flux_ff};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_enable_ff <= 1'b1;
         clip_flux_ff    <= 1'b0;
      end else begin
         shape_enable_ff <= shape_enable_in;
         clip_flux_ff    <= clip_flux_in;
      end
   end

   // pixel pipeline and accumulators
   wma_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_offset_x     (req_offset_x),
      .req_offset_y     (req_offset_y),
      .req_pixel_weight (req_pixel_weight),
      .req_pixel_value  (req_pixel_value),
      .req_last_pixel   (req_last_pixel),
      .slot_free        (queue_pop),
      .push             (push),
      .push_data        (push_data)
   );

   // finished objects waiting for the back end
   wma_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (queue_pop),
      .head      (queue_head),
      .empty     (queue_empty)
   );

   // shared serial divider
   wma_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // result computation
   wma_back u_back (
      .clock              (clock),
      .reset              (reset),
      .shape_enable       (shape_enable_ff),
      .clip_negative_flux (clip_flux_ff),
      .queue_empty        (queue_empty),
      .queue_head         (queue_head),
      .queue_pop          (queue_pop),
      .div_req            (div_req),
      .div_rsp            (div_rsp),
      .rsp_valid          (rsp_valid),
      .rsp_flux_value     (rsp_flux_value),
      .rsp_moment_xx      (rsp_moment_xx),
      .rsp_moment_yy      (rsp_moment_yy),
      .rsp_moment_xy      (rsp_moment_xy),
      .rsp_result_status  (rsp_result_status)
   );

endmodule

### hw/rtl/wma_front.sv
// pixel pipeline: products, saturating sums and object hand-off
`timescale 1ns / 1ps

module wma_front import wma_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [OFFSET_W-1:0] req_offset_x,
   input  logic signed [OFFSET_W-1:0] req_offset_y,
   input  logic        [WEIGHT_W-1:0] req_pixel_weight,
   input  logic signed [VALUE_W-1:0]  req_pixel_value,
   input  logic                       req_last_pixel,
   input  logic                       slot_free,
   output logic                       push,
   output sums_type                   push_data
);

   localparam int WD_W       = WEIGHT_W + VALUE_W;
   localparam int WW_W       = 2 * WEIGHT_W;
   localparam int SQ_W       = 2 * OFFSET_W;
   localparam int MOM_TERM_W = WD_W + SQ_W;

   logic accept;

   // stage 0: captured pixel
   logic                       s0_valid_ff;
   logic                       s0_last_ff;
   logic signed [OFFSET_W-1:0] s0_x_ff;
   logic signed [OFFSET_W-1:0] s0_y_ff;
   logic        [WEIGHT_W-1:0] s0_w_ff;
   logic signed [VALUE_W-1:0]  s0_d_ff;

   // stage 1: first products
   logic signed [WD_W:0]       wd_full;
   logic signed [SQ_W-1:0]     xx_full;
   logic signed [SQ_W-1:0]     yy_full;
   logic signed [SQ_W-1:0]     xy_full;
   logic        [WW_W-1:0]     ww_full;
   logic                       s1_valid_ff;
   logic                       s1_last_ff;
   logic        [WEIGHT_W-1:0] s1_w_ff;
   logic        [WW_W-1:0]     s1_ww_ff;
   logic signed [WD_W-1:0]     s1_wd_ff;
   logic signed [SQ_W-1:0]     s1_xx_ff;
   logic signed [SQ_W-1:0]     s1_yy_ff;
   logic signed [SQ_W-1:0]     s1_xy_ff;

   // stage 2: moment terms
   logic signed [MOM_TERM_W-1:0] pxx_full;
   logic signed [MOM_TERM_W-1:0] pyy_full;
   logic signed [MOM_TERM_W-1:0] pxy_full;
   logic                         s2_valid_ff;
   logic                         s2_last_ff;
   logic        [WEIGHT_W-1:0]   s2_w_ff;
   logic        [WW_W-1:0]       s2_ww_ff;
   logic signed [WD_W-1:0]       s2_wd_ff;
   logic signed [MOM_TERM_W-1:0] s2_pxx_ff;
   logic signed [MOM_TERM_W-1:0] s2_pyy_ff;
   logic signed [MOM_TERM_W-1:0] s2_pxy_ff;

   // stage 3: accumulators
   logic [SUM_W_W:0]        w_total;
   logic [SUM_WW_W:0]       ww_total;
   logic signed [SUM_WD_W:0] wd_total;
   sums_type                sums_new;
   sums_type                sums_in;
   sums_type                sums_ff;

   // objects in flight or waiting in the queue
   logic [QUEUE_CNT_W-1:0] reserve_in;
   logic [QUEUE_CNT_W-1:0] reserve_ff;

   // saturating add of one moment term
   function automatic logic signed [SUM_MOM_W-1:0] mom_acc(
      input logic signed [SUM_MOM_W-1:0]  acc,
      input logic signed [MOM_TERM_W-1:0] term
   );
      logic signed [SUM_MOM_W:0] total;
      total = {acc[SUM_MOM_W-1], acc}
            + {{(SUM_MOM_W + 1 - MOM_TERM_W){term[MOM_TERM_W-1]}}, term};
      if (total[SUM_MOM_W] != total[SUM_MOM_W-1]) begin
         return total[SUM_MOM_W] ? {1'b1, {(SUM_MOM_W - 1){1'b0}}}
                                 : {1'b0, {(SUM_MOM_W - 1){1'b1}}};
      end
      return total[SUM_MOM_W-1:0];
   endfunction

   assign accept = start && !busy;
   assign busy   = (reserve_ff == QUEUE_CNT_W'(QUEUE_DEPTH));

   // reservation count: one slot per last pixel until the back end takes it
   always_comb begin
      reserve_in = reserve_ff;
      case ({accept && req_last_pixel, slot_free})
         2'b10:   reserve_in = reserve_ff + QUEUE_CNT_W'(1);
         2'b01:   reserve_in = reserve_ff - QUEUE_CNT_W'(1);
         default: reserve_in = reserve_ff;
      endcase
   end

   // stage 0 capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
      end
      if (accept) begin
         s0_last_ff <= req_last_pixel;
         s0_x_ff    <= req_offset_x;
         s0_y_ff    <= req_offset_y;
         s0_w_ff    <= req_pixel_weight;
         s0_d_ff    <= req_pixel_value;
      end
   end

   // weight times value, squares of offsets, weight squared
   assign wd_full = $signed({1'b0, s0_w_ff}) * s0_d_ff;
   assign xx_full = s0_x_ff * s0_x_ff;
   assign yy_full = s0_y_ff * s0_y_ff;
   assign xy_full = s0_x_ff * s0_y_ff;
   assign ww_full = s0_w_ff * s0_w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
      end
      s1_last_ff <= s0_last_ff;
      s1_w_ff    <= s0_w_ff;
      s1_ww_ff   <= ww_full;
      s1_wd_ff   <= $signed(wd_full[WD_W-1:0]);
      s1_xx_ff   <= xx_full;
      s1_yy_ff   <= yy_full;
      s1_xy_ff   <= xy_full;
   end

   // weighted data times offset products
   assign pxx_full = s1_wd_ff * s1_xx_ff;
   assign pyy_full = s1_wd_ff * s1_yy_ff;
   assign pxy_full = s1_wd_ff * s1_xy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_last_ff <= s1_last_ff;
      s2_w_ff    <= s1_w_ff;
      s2_ww_ff   <= s1_ww_ff;
      s2_wd_ff   <= s1_wd_ff;
      s2_pxx_ff  <= pxx_full;
      s2_pyy_ff  <= pyy_full;
      s2_pxy_ff  <= pxy_full;
   end

   // saturating accumulation
   always_comb begin
      w_total  = {1'b0, sums_ff.sum_weight}
               + {{(SUM_W_W + 1 - WEIGHT_W){1'b0}}, s2_w_ff};
      ww_total = {1'b0, sums_ff.sum_weight_sq}
               + {{(SUM_WW_W + 1 - WW_W){1'b0}}, s2_ww_ff};
      wd_total = {sums_ff.sum_weighted_data[SUM_WD_W-1], sums_ff.sum_weighted_data}
               + {{(SUM_WD_W + 1 - WD_W){s2_wd_ff[WD_W-1]}}, s2_wd_ff};

      sums_new.sum_weight    = w_total[SUM_W_W] ? {SUM_W_W{1'b1}} : w_total[SUM_W_W-1:0];
      sums_new.sum_weight_sq = ww_total[SUM_WW_W] ? {SUM_WW_W{1'b1}}
                                                  : ww_total[SUM_WW_W-1:0];
      if (wd_total[SUM_WD_W] != wd_total[SUM_WD_W-1]) begin
         sums_new.sum_weighted_data = wd_total[SUM_WD_W]
                                    ? {1'b1, {(SUM_WD_W - 1){1'b0}}}
                                    : {1'b0, {(SUM_WD_W - 1){1'b1}}};
      end else begin
         sums_new.sum_weighted_data = wd_total[SUM_WD_W-1:0];
      end
      sums_new.sum_wd_xx = mom_acc(sums_ff.sum_wd_xx, s2_pxx_ff);
      sums_new.sum_wd_yy = mom_acc(sums_ff.sum_wd_yy, s2_pyy_ff);
      sums_new.sum_wd_xy = mom_acc(sums_ff.sum_wd_xy, s2_pxy_ff);

      sums_in = sums_ff;
      if (s2_valid_ff) begin
         sums_in = s2_last_ff ? '0 : sums_new;
      end
   end

   // last pixel hands the finished sums to the queue
   assign push      = s2_valid_ff && s2_last_ff;
   assign push_data = sums_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff    <= '0;
         reserve_ff <= '0;
      end else begin
         sums_ff    <= sums_in;
         reserve_ff <= reserve_in;
      end
   end

endmodule

### hw/rtl/wma_queue.sv
// short queue of finished object sums between front and back
`timescale 1ns / 1ps
`include "weighted_moment_accumulator_assert.svh"

module wma_queue import wma_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  sums_type push_data,
   input  logic     pop,
   output sums_type head,
   output logic     empty
);

   sums_type               entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic [QUEUE_CNT_W-1:0] count_ff;

   assign head  = entries_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                   ? '0 : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
                   ? '0 : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + QUEUE_CNT_W'(1);
         2'b01:   count_in = count_ff - QUEUE_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   `WMA_ASSERT_IMPLY(a_no_push_when_full, clock, reset, push, count_ff != QUEUE_CNT_W'(QUEUE_DEPTH), "object pushed into a full queue")
   `WMA_ASSERT_IMPLY(a_no_pop_when_empty, clock, reset, pop, count_ff != '0, "object popped from an empty queue")

endmodule

### hw/rtl/wma_divider.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`include "weighted_moment_accumulator_assert.svh"

module wma_divider import wma_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_in;
   logic                 busy_ff;
   logic                 done_in;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] count_in;
   logic [DIV_CNT_W-1:0] count_ff;
   logic [DIV_NUM_W-1:0] num_in;
   logic [DIV_NUM_W-1:0] num_ff;
   logic [DIV_DEN_W-1:0] rem_in;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] den_in;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;

   // one compare and subtract step
   assign trial = {rem_ff, num_ff[DIV_NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (div_req.go) begin
         busy_in  = 1'b1;
         count_in = '0;
         num_in   = div_req.numerator;
         rem_in   = '0;
         den_in   = div_req.denominator;
      end else if (busy_ff) begin
         num_in   = {num_ff[DIV_NUM_W-2:0], fits};
         rem_in   = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         count_in = count_ff + DIV_CNT_W'(1);
         if (count_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
   end

   // quotient has shifted fully into the numerator register
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = num_ff;

   `WMA_ASSERT_IMPLY(a_go_while_idle, clock, reset, div_req.go, !busy_ff, "divider started while busy")

endmodule

### hw/rtl/wma_back.sv
// result sequencer: flux product, divisions, saturation and result strobe
`timescale 1ns / 1ps
`include "weighted_moment_accumulator_assert.svh"

module wma_back import wma_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       shape_enable,
   input  logic                       clip_negative_flux,
   input  logic                       queue_empty,
   input  sums_type                   queue_head,
   output logic                       queue_pop,
   output div_req_type                div_req,
   input  div_rsp_type                div_rsp,
   output logic                       rsp_valid,
   output logic signed [FLUX_W-1:0]   rsp_flux_value,
   output logic signed [MOMENT_W-1:0] rsp_moment_xx,
   output logic signed [MOMENT_W-1:0] rsp_moment_yy,
   output logic signed [MOMENT_W-1:0] rsp_moment_xy,
   output logic        [STATUS_W-1:0] rsp_result_status
);

   localparam int HALF_W   = SUM_WD_W / 2;
   localparam int PP_W     = SUM_W_W + HALF_W;
   localparam int PROD_W   = SUM_W_W + SUM_WD_W - 1;
   localparam int FLUX_SHL = DIV_NUM_W - PROD_W;
   localparam int MOM_PAD  = DIV_NUM_W - SUM_MOM_W - 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_MUL_LO,
      S_MUL_HI,
      S_DIV_GO,
      S_DIV_WAIT,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      SEL_FLUX,
      SEL_XX,
      SEL_YY,
      SEL_XY
   } sel_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_WEIGHT = 2'd1,
      STATUS_NO_DATA   = 2'd2
   } status_type;

   state_type                  state_in;
   state_type                  state_ff;
   sel_type                    sel_in;
   sel_type                    sel_ff;
   sums_type                   ent_in;
   sums_type                   ent_ff;
   logic        [PROD_W-1:0]   prod_in;
   logic        [PROD_W-1:0]   prod_ff;
   logic signed [FLUX_W-1:0]   flux_in;
   logic signed [FLUX_W-1:0]   flux_ff;
   logic signed [MOMENT_W-1:0] mxx_in;
   logic signed [MOMENT_W-1:0] mxx_ff;
   logic signed [MOMENT_W-1:0] myy_in;
   logic signed [MOMENT_W-1:0] myy_ff;
   logic signed [MOMENT_W-1:0] mxy_in;
   logic signed [MOMENT_W-1:0] mxy_ff;
   status_type                 status_in;
   status_type                 status_ff;
   logic                       valid_in;
   logic                       valid_ff;

   logic [SUM_WD_W-1:0]  swd_mag;
   logic [PP_W-1:0]      pp_lo;
   logic [PP_W-1:0]      pp_hi;
   logic                 div_neg;
   logic [FLUX_W-1:0]    flux_q;
   logic [MOMENT_W-1:0]  mom_q;
   logic [SUM_MOM_W-1:0] mom_num_mag;
   logic                 mom_sign;

   // magnitude of a moment sum
   function automatic logic [SUM_MOM_W-1:0] mag64(input logic signed [SUM_MOM_W-1:0] s);
      return s[SUM_MOM_W-1] ? (~s + SUM_MOM_W'(1)) : s;
   endfunction

   // saturate a quotient magnitude to the flux field and apply the sign
   function automatic logic [FLUX_W-1:0] sat_flux(
      input logic [DIV_NUM_W-1:0] q,
      input logic                 neg
   );
      logic [FLUX_W-1:0] mag;
      if (q[DIV_NUM_W-1:FLUX_W-1] != '0) begin
         mag = neg ? {1'b1, {(FLUX_W - 1){1'b0}}} : {1'b0, {(FLUX_W - 1){1'b1}}};
      end else begin
         mag = {1'b0, q[FLUX_W-2:0]};
      end
      return neg ? (~mag + FLUX_W'(1)) : mag;
   endfunction

   // saturate a quotient magnitude to a moment field and apply the sign
   function automatic logic [MOMENT_W-1:0] sat_moment(
      input logic [DIV_NUM_W-1:0] q,
      input logic                 neg
   );
      logic [MOMENT_W-1:0] mag;
      if (q[DIV_NUM_W-1:MOMENT_W-1] != '0) begin
         mag = neg ? {1'b1, {(MOMENT_W - 1){1'b0}}} : {1'b0, {(MOMENT_W - 1){1'b1}}};
      end else begin
         mag = {1'b0, q[MOMENT_W-2:0]};
      end
      return neg ? (~mag + MOMENT_W'(1)) : mag;
   endfunction

   // weighted data magnitude and its two partial products with the weight sum
   assign swd_mag = ent_ff.sum_weighted_data[SUM_WD_W-1]
                  ? (~ent_ff.sum_weighted_data + SUM_WD_W'(1))
                  : ent_ff.sum_weighted_data;
   assign pp_lo   = ent_ff.sum_weight * swd_mag[HALF_W-1:0];
   assign pp_hi   = ent_ff.sum_weight * swd_mag[SUM_WD_W-1:HALF_W];

   // division operands for the current step
   always_comb begin
      mom_num_mag = '0;
      mom_sign    = 1'b0;
      unique case (sel_ff)
         SEL_XX: begin
            mom_num_mag = mag64(ent_ff.sum_wd_xx);
            mom_sign    = ent_ff.sum_wd_xx[SUM_MOM_W-1];
         end
         SEL_YY: begin
            mom_num_mag = mag64(ent_ff.sum_wd_yy);
            mom_sign    = ent_ff.sum_wd_yy[SUM_MOM_W-1];
         end
         SEL_XY: begin
            mom_num_mag = mag64(ent_ff.sum_wd_xy);
            mom_sign    = ent_ff.sum_wd_xy[SUM_MOM_W-1];
         end
         default: begin
            mom_num_mag = '0;
            mom_sign    = 1'b0;
         end
      endcase

      div_req.go = (state_ff == S_DIV_GO);
      if (sel_ff == SEL_FLUX) begin
         div_req.numerator   = {prod_ff, {FLUX_SHL{1'b0}}};
         div_req.denominator = ent_ff.sum_weight_sq;
         div_neg             = ent_ff.sum_weighted_data[SUM_WD_W-1];
      end else begin
         div_req.numerator   = {{MOM_PAD{1'b0}}, mom_num_mag, 1'b0};
         div_req.denominator = {{(DIV_DEN_W - SUM_WD_W){1'b0}}, swd_mag};
         div_neg             = mom_sign ^ ent_ff.sum_weighted_data[SUM_WD_W-1];
      end
   end

   assign flux_q = sat_flux(div_rsp.quotient, div_neg);
   assign mom_q  = sat_moment(div_rsp.quotient, div_neg);

   assign queue_pop = (state_ff == S_IDLE) && !queue_empty;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      ent_in    = ent_ff;
      prod_in   = prod_ff;
      flux_in   = flux_ff;
      mxx_in    = mxx_ff;
      myy_in    = myy_ff;
      mxy_in    = mxy_ff;
      status_in = status_ff;
      valid_in  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!queue_empty) begin
               ent_in    = queue_head;
               sel_in    = SEL_FLUX;
               flux_in   = '0;
               mxx_in    = '0;
               myy_in    = '0;
               mxy_in    = '0;
               status_in = STATUS_OK;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            if (ent_ff.sum_weight_sq == '0) begin
               status_in = STATUS_NO_WEIGHT;
               state_in  = S_EMIT;
            end else begin
               state_in = S_MUL_LO;
            end
         end
         S_MUL_LO: begin
            prod_in  = {{(PROD_W - PP_W){1'b0}}, pp_lo};
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            prod_in  = prod_ff + {pp_hi[PROD_W-HALF_W-1:0], {HALF_W{1'b0}}};
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               unique case (sel_ff)
                  SEL_FLUX: begin
                     flux_in = (clip_negative_flux && flux_q[FLUX_W-1]) ? '0 : flux_q;
                     if (!shape_enable) begin
                        state_in = S_EMIT;
                     end else if (ent_ff.sum_weighted_data == '0) begin
                        status_in = STATUS_NO_DATA;
                        state_in  = S_EMIT;
                     end else begin
                        sel_in   = SEL_XX;
                        state_in = S_DIV_GO;
                     end
                  end
                  SEL_XX: begin
                     mxx_in   = mom_q;
                     sel_in   = SEL_YY;
                     state_in = S_DIV_GO;
                  end
                  SEL_YY: begin
                     myy_in   = mom_q;
                     sel_in   = SEL_XY;
                     state_in = S_DIV_GO;
                  end
                  SEL_XY: begin
                     mxy_in   = mom_q;
                     state_in = S_EMIT;
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end
         S_EMIT: begin
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      sel_ff    <= sel_in;
      ent_ff    <= ent_in;
      prod_ff   <= prod_in;
      flux_ff   <= flux_in;
      mxx_ff    <= mxx_in;
      myy_ff    <= myy_in;
      mxy_ff    <= mxy_in;
      status_ff <= status_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_flux_value    = flux_ff;
   assign rsp_moment_xx     = mxx_ff;
   assign rsp_moment_yy     = myy_ff;
   assign rsp_moment_xy     = mxy_ff;
   assign rsp_result_status = status_ff;

   `WMA_ASSERT_NEXT(a_strobe_one_cycle, clock, reset, rsp_valid, !rsp_valid, "result strobe held longer than one cycle")
   `WMA_ASSERT_IMPLY(a_done_while_waiting, clock, reset, div_rsp.done, state_ff == S_DIV_WAIT, "divider finished outside a wait state")

endmodule

### dv/tb.sv
// self-checking testbench of the weighted moment accumulator
`timescale 1ns / 1ps

module tb;
   import wma_pkg::*;

   // register map, one register per 32-bit word
   localparam logic [CSR_ADDR_W-1:0] ADDR_SHAPE_ENABLE = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_CLIP_FLUX    = 3'd4;

   // register settings after the reset phase: bit i belongs to phase i
   localparam logic [3:0] SHAPE_PLAN = 4'b1010;
   localparam logic [3:0] CLIP_PLAN  = 4'b0110;
   localparam int PHASES = 4;

   localparam int PIXELS_PER_PHASE = 170;
   localparam int LONG_OBJECT_PIXELS = 4100;
   localparam int MAX_WEIGHT = 131071;
   localparam int UNIT_WEIGHT = 65536;
   localparam int SETTLE_CYCLES = 400;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int REPORT_LIMIT = 10;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_WEIGHT = 2'd1,
      STATUS_NO_DATA   = 2'd2
   } status_e;

   typedef enum {OBJ_PLAIN, OBJ_NO_WEIGHT, OBJ_NO_VALUE, OBJ_CANCELLING, OBJ_NEGATIVE}
      object_kind_e;

   typedef struct {
      logic signed [OFFSET_W-1:0] offset_x;
      logic signed [OFFSET_W-1:0] offset_y;
      logic        [WEIGHT_W-1:0] weight;
      logic signed [VALUE_W-1:0]  value;
      logic                       last;
      int unsigned                gap;
   } pixel_t;

   typedef struct {
      logic signed [FLUX_W-1:0]   flux;
      logic signed [MOMENT_W-1:0] xx;
      logic signed [MOMENT_W-1:0] yy;
      logic signed [MOMENT_W-1:0] xy;
      logic        [STATUS_W-1:0] status;
   } moments_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [OFFSET_W-1:0] req_offset_x = '0;
   logic signed [OFFSET_W-1:0] req_offset_y = '0;
   logic        [WEIGHT_W-1:0] req_pixel_weight = '0;
   logic signed [VALUE_W-1:0]  req_pixel_value = '0;
   logic                       req_last_pixel = 1'b0;
   logic                       rsp_valid;
   logic signed [FLUX_W-1:0]   rsp_flux_value;
   logic signed [MOMENT_W-1:0] rsp_moment_xx;
   logic signed [MOMENT_W-1:0] rsp_moment_yy;
   logic signed [MOMENT_W-1:0] rsp_moment_xy;
   logic        [STATUS_W-1:0] rsp_result_status;
   logic                       psel = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]      paddr = '0;
   logic [CSR_DATA_W-1:0]      pwdata = '0;
   logic [CSR_DATA_W-1:0]      prdata;
   logic                       pready;

   // pending pixels and results still to come
   pixel_t   pixel_backlog[$];
   moments_t results_due[$];

   logic pixel_accepted = 1'b0;
   int unsigned gap_count = 0;
   int cycle_count = 0;
   int busy_cycles = 0;
   int pixel_count = 0;
   int object_count = 0;
   int results_checked = 0;
   int failure_count = 0;
   int status_seen[3] = '{0, 0, 0};

   // predictor state: register copies and the six running sums
   bit                          model_shape = 1'b1;
   bit                          model_clip = 1'b0;
   logic        [SUM_W_W-1:0]   model_sw = '0;
   logic        [SUM_WW_W-1:0]  model_sww = '0;
   logic signed [SUM_WD_W-1:0]  model_swd = '0;
   logic signed [SUM_MOM_W-1:0] model_sxx = '0;
   logic signed [SUM_MOM_W-1:0] model_syy = '0;
   logic signed [SUM_MOM_W-1:0] model_sxy = '0;

   weighted_moment_accumulator u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_offset_x(req_offset_x), .req_offset_y(req_offset_y),
      .req_pixel_weight(req_pixel_weight), .req_pixel_value(req_pixel_value),
      .req_last_pixel(req_last_pixel),
      .rsp_valid(rsp_valid), .rsp_flux_value(rsp_flux_value),
      .rsp_moment_xx(rsp_moment_xx), .rsp_moment_yy(rsp_moment_yy),
      .rsp_moment_xy(rsp_moment_xy), .rsp_result_status(rsp_result_status),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // saturate to a signed field
   function automatic logic signed [127:0] clamp_signed(input logic signed [127:0] v,
                                                        input int width);
      logic signed [127:0] top;
      top = (128'sd1 <<< (width - 1)) - 128'sd1;
      if (v > top) return top;
      if (v < -top - 128'sd1) return -top - 128'sd1;
      return v;
   endfunction

   // saturate to an unsigned field
   function automatic logic signed [127:0] clamp_unsigned(input logic signed [127:0] v,
                                                          input int width);
      logic signed [127:0] top;
      top = (128'sd1 <<< width) - 128'sd1;
      return (v > top) ? top : v;
   endfunction

   function automatic logic [127:0] magnitude(input logic signed [127:0] v);
      return (v < 0) ? -v : v;
   endfunction

   // quotient truncated toward zero, then saturated to the field's signed range
   function automatic logic signed [127:0] signed_quotient(input logic [127:0] num_mag,
         input logic [127:0] den_mag, input bit negative, input int width);
      logic [127:0] q;
      logic [127:0] lim;
      q = num_mag / den_mag;
      lim = (128'd1 << (width - 1)) - (negative ? 128'd0 : 128'd1);
      if (q > lim) q = lim;
      return negative ? -$signed(q) : $signed(q);
   endfunction

   // second moment 2*s/swd in 1/16 pixel squared
   function automatic logic signed [127:0] moment_of(input logic signed [127:0] s,
                                                     input logic signed [127:0] swd);
      return signed_quotient(magnitude(s) << 1, magnitude(swd), (s < 0) != (swd < 0),
                             MOMENT_W);
   endfunction

   // add one pixel into the sums; on the last pixel of an object work out its result
   function automatic bit accumulate_pixel(input pixel_t p, output moments_t r);
      logic signed [127:0] x, y, w, d, wd, acc, swd, flux;
      logic        [127:0] num;
      x = p.offset_x;
      y = p.offset_y;
      w = p.weight;
      d = p.value;
      wd = w * d;
      acc = model_sw;
      model_sw = clamp_unsigned(acc + w, SUM_W_W);
      acc = model_sww;
      model_sww = clamp_unsigned(acc + w * w, SUM_WW_W);
      acc = model_swd;
      model_swd = clamp_signed(acc + wd, SUM_WD_W);
      acc = model_sxx;
      model_sxx = clamp_signed(acc + wd * x * x, SUM_MOM_W);
      acc = model_syy;
      model_syy = clamp_signed(acc + wd * y * y, SUM_MOM_W);
      acc = model_sxy;
      model_sxy = clamp_signed(acc + wd * x * y, SUM_MOM_W);
      r.flux = '0;
      r.xx = '0;
      r.yy = '0;
      r.xy = '0;
      r.status = STATUS_OK;
      if (!p.last) return 1'b0;

      // flux = sw * swd / sww in 1/256 counts, moments divide by swd
      if (model_sww == 0) begin
         r.status = STATUS_NO_WEIGHT;
      end else begin
         swd = model_swd;
         num = magnitude(swd) * model_sw;
         num = num << 8;
         flux = signed_quotient(num, model_sww, swd < 0, FLUX_W);
         if (model_clip && flux < 0) flux = 0;
         r.flux = flux[FLUX_W-1:0];
         if (model_shape) begin
            if (model_swd == 0) begin
               r.status = STATUS_NO_DATA;
            end else begin
               acc = moment_of(model_sxx, swd);
               r.xx = acc[MOMENT_W-1:0];
               acc = moment_of(model_syy, swd);
               r.yy = acc[MOMENT_W-1:0];
               acc = moment_of(model_sxy, swd);
               r.xy = acc[MOMENT_W-1:0];
            end
         end
      end
      model_sw = '0;
      model_sww = '0;
      model_swd = '0;
      model_sxx = '0;
      model_syy = '0;
      model_sxy = '0;
      return 1'b1;
   endfunction

   // idle time before a pixel: mostly none, some short, a few long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(12, 60);
   endfunction

   task automatic add_pixel(input int x, input int y, input int w, input int v,
                            input bit last, input int unsigned gap);
      pixel_t p;
      p.offset_x = OFFSET_W'(x);
      p.offset_y = OFFSET_W'(y);
      p.weight = WEIGHT_W'(w);
      p.value = VALUE_W'(v);
      p.last = last;
      p.gap = gap;
      pixel_backlog.push_back(p);
   endtask

   // one object of random length and content; returns its pixel count
   task automatic add_random_object(output int added);
      object_kind_e kind;
      int unsigned r;
      int len, w, v, prev_v;
      bit burst;
      r = $urandom_range(0, 99);
      if (r < 8) kind = OBJ_NO_WEIGHT;
      else if (r < 16) kind = OBJ_NO_VALUE;
      else if (r < 24) kind = OBJ_CANCELLING;
      else if (r < 36) kind = OBJ_NEGATIVE;
      else kind = OBJ_PLAIN;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      if (kind == OBJ_CANCELLING && len % 2 != 0) len++;
      burst = ($urandom_range(0, 3) == 0);
      prev_v = 0;
      w = 0;
      for (int i = 0; i < len; i++) begin
         // weight: edges and full random range
         if (kind != OBJ_CANCELLING || i % 2 == 0) begin
            case ($urandom_range(0, 5))
               0: w = 0;
               1: w = UNIT_WEIGHT;
               2: w = MAX_WEIGHT;
               default: w = $urandom_range(0, MAX_WEIGHT);
            endcase
         end
         case ($urandom_range(0, 5))
            0: v = -32768;
            1: v = 32767;
            default: v = int'($urandom_range(0, 65535)) - 32768;
         endcase
         case (kind)
            OBJ_NO_WEIGHT: w = 0;
            OBJ_NO_VALUE: v = 0;
            OBJ_NEGATIVE: v = -int'($urandom_range(1, 32768));
            OBJ_CANCELLING: v = (i % 2 == 0) ? int'($urandom_range(0, 32767)) : -prev_v;
            default: ;
         endcase
         prev_v = v;
         add_pixel($urandom_range(0, 2047), $urandom_range(0, 2047), w, v, i == len - 1,
                   burst ? 0 : pick_gap());
      end
      added = len;
   endtask

   task automatic add_random_pixels(input int count);
      int added, got;
      added = 0;
      while (added < count) begin
         add_random_object(got);
         added += got;
      end
   endtask

   // a long object, back to back; large weights and values drive its sums past saturation
   task automatic add_long_object(input int x, input int y, input int w, input int v);
      for (int i = 0; i < LONG_OBJECT_PIXELS; i++)
         add_pixel(x, y, w, v, i == LONG_OBJECT_PIXELS - 1, 0);
   endtask

   // hand-picked objects for the corners of the arithmetic
   task automatic add_directed_objects();
      // weights of 1.0 and above with extreme offsets and values
      add_pixel(-1024, 1023, MAX_WEIGHT, 32767, 1'b1, pick_gap());
      add_pixel(1023, -1024, UNIT_WEIGHT, -32768, 1'b1, pick_gap());
      // zero weight-square sum
      add_pixel(5, -3, 0, 100, 1'b1, pick_gap());
      // zero weighted data sum, plain and by cancellation
      add_pixel(7, 9, UNIT_WEIGHT, 0, 1'b1, pick_gap());
      add_pixel(3, 4, 1000, 777, 1'b0, pick_gap());
      add_pixel(-2, 1, 1000, -777, 1'b1, pick_gap());
      // tiny data sum under huge moment sums: moments saturate both ways
      add_pixel(1023, -1024, MAX_WEIGHT, 32767, 1'b0, pick_gap());
      add_pixel(0, 0, MAX_WEIGHT, -32767, 1'b0, pick_gap());
      add_pixel(0, 0, 1, 1, 1'b1, pick_gap());
      add_pixel(1023, -1024, MAX_WEIGHT, 32767, 1'b0, pick_gap());
      add_pixel(0, 0, MAX_WEIGHT, -32767, 1'b0, pick_gap());
      add_pixel(0, 0, 1, -1, 1'b1, pick_gap());
      // centered pixels give zero moments
      add_pixel(0, 0, 20000, 12, 1'b0, pick_gap());
      add_pixel(0, 0, 30000, -5, 1'b0, pick_gap());
      add_pixel(0, 0, 40000, 9, 1'b1, pick_gap());
      // smallest nonzero weight
      add_pixel(1, -1, 1, 1, 1'b1, pick_gap());
      // opposite corners
      add_pixel(-1024, -1024, UNIT_WEIGHT, 1000, 1'b0, pick_gap());
      add_pixel(1023, 1023, UNIT_WEIGHT, 1000, 1'b1, pick_gap());
   endtask

   // wait until every pixel is taken and every result is back, then let the block settle
   task automatic drain_results();
      while (pixel_backlog.size() != 0 || start) @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write: setup cycle, then access cycle until pready
   task automatic write_register(input logic [CSR_ADDR_W-1:0] addr, input bit value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= CSR_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (addr == ADDR_SHAPE_ENABLE) model_shape = value;
      else model_clip = value;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic report_failure(input string msg);
      failure_count++;
      if (failure_count <= REPORT_LIMIT) $display("%s", msg);
   endtask

   // pixel driver: holds a transfer until accepted, inserts the gap of the next pixel
   always @(negedge clock) begin : pixel_driver
      pixel_t next_pixel;
      if (reset) begin
         start <= 1'b0;
         gap_count <= 0;
      end else if (!start || pixel_accepted) begin
         if (pixel_backlog.size() == 0) begin
            start <= 1'b0;
         end else if (gap_count < pixel_backlog[0].gap) begin
            start <= 1'b0;
            gap_count <= gap_count + 1;
         end else begin
            next_pixel = pixel_backlog.pop_front();
            req_offset_x <= next_pixel.offset_x;
            req_offset_y <= next_pixel.offset_y;
            req_pixel_weight <= next_pixel.weight;
            req_pixel_value <= next_pixel.value;
            req_last_pixel <= next_pixel.last;
            start <= 1'b1;
            gap_count <= 0;
         end
      end
   end

   // accepted pixels feed the predictor
   always @(posedge clock) begin : pixel_intake
      pixel_t taken;
      moments_t due;
      if (reset) begin
         pixel_accepted <= 1'b0;
      end else begin
         pixel_accepted <= start && !busy;
         if (start && !busy) begin
            taken.offset_x = req_offset_x;
            taken.offset_y = req_offset_y;
            taken.weight = req_pixel_weight;
            taken.value = req_pixel_value;
            taken.last = req_last_pixel;
            taken.gap = 0;
            pixel_count++;
            if (accumulate_pixel(taken, due)) begin
               results_due.push_back(due);
               object_count++;
            end
         end
      end
   end

   // result monitor: compare each strobed result with the oldest expected one
   always @(posedge clock) begin : result_checker
      moments_t want;
      if (!reset && rsp_valid) begin
         if (results_due.size() == 0) begin
            report_failure($sformatf("unexpected result: flux %0d status %0d",
                                     rsp_flux_value, rsp_result_status));
         end else begin
            want = results_due.pop_front();
            results_checked++;
            if (rsp_result_status <= STATUS_NO_DATA) status_seen[rsp_result_status]++;
            if (rsp_flux_value !== want.flux || rsp_moment_xx !== want.xx ||
                rsp_moment_yy !== want.yy || rsp_moment_xy !== want.xy ||
                rsp_result_status !== want.status)
               report_failure($sformatf({"result %0d mismatch (expected/actual): ",
                  "flux %0d/%0d xx %0d/%0d yy %0d/%0d xy %0d/%0d status %0d/%0d"},
                  results_checked, want.flux, rsp_flux_value, want.xx, rsp_moment_xx,
                  want.yy, rsp_moment_yy, want.xy, rsp_moment_xy, want.status,
                  rsp_result_status));
         end
      end
   end

   // cycle limit and busy statistics
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (busy) busy_cycles <= busy_cycles + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pixels pending, %0d results pending",
                  cycle_count, pixel_backlog.size(), results_due.size());
         $display("tb NOT OK");
         $finish;
      end
   end

   // test sequence: directed objects, long objects (the first saturating), then random phases
   initial begin : run_plan
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_directed_objects();
      drain_results();
      add_long_object(1023, -1024, MAX_WEIGHT, 32767);
      add_long_object(17, -9, 1, 32767);
      add_long_object(-1024, -1024, 1, -32768);
      drain_results();
      add_random_pixels(PIXELS_PER_PHASE);
      drain_results();

      for (int i = 0; i < PHASES; i++) begin
         write_register(ADDR_SHAPE_ENABLE, SHAPE_PLAN[i]);
         write_register(ADDR_CLIP_FLUX, CLIP_PLAN[i]);
         add_random_pixels(PIXELS_PER_PHASE);
         drain_results();
      end

      $display("sent %0d pixels in %0d objects under %0d register settings, busy %0d cycles",
               pixel_count, object_count, PHASES + 1, busy_cycles);
      $display("checked %0d results: %0d ok, %0d no weight, %0d no data; %0d failures",
               results_checked, status_seen[STATUS_OK], status_seen[STATUS_NO_WEIGHT],
               status_seen[STATUS_NO_DATA], failure_count);
      if (failure_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/wma_pkg.sv
hw/rtl/wma_front.sv
hw/rtl/wma_queue.sv
hw/rtl/wma_divider.sv
hw/rtl/wma_back.sv
hw/rtl/weighted_moment_accumulator.sv
dv/tb.sv
